### hdl/utf8d_pkg.sv
// Package with shared types and constants for the UTF-8 stream decoder.
`timescale 1ns / 1ps
`default_nettype none

package utf8d_pkg;

	// Input beat: one raw byte and the end-of-buffer flag.
	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_buffer;
	} utf8d_in_t;

	// Result beat.
	typedef struct packed {
		logic [30:0] code_point;
		logic        is_error;
		logic        buffer_done;
		logic [15:0] char_count;
	} utf8d_out_t;

	// Sequence state carried between bytes; the character count travels separately.
	typedef struct packed {
		logic [2:0]  bytes_remaining;
		logic [2:0]  sequence_length;
		logic [7:0]  lead_byte;
		logic        second_pending;
		logic [30:0] accumulator;
		logic        discarding;
	} utf8d_state_t;

	// What the decode step hands to the result register.
	typedef struct packed {
		logic       emit;
		utf8d_out_t res;
	} utf8d_emit_t;

	// Lead byte boundaries.
	localparam logic [7:0] LEAD_ASCII_END = 8'h80;
	localparam logic [7:0] LEAD_CONT_END  = 8'hC0;
	localparam logic [7:0] LEAD2_END      = 8'hE0;
	localparam logic [7:0] LEAD3_END      = 8'hF0;
	localparam logic [7:0] LEAD4_END      = 8'hF8;
	localparam logic [7:0] LEAD5_END      = 8'hFC;
	localparam logic [7:0] LEAD6_END      = 8'hFE;

	// Payload masks for each lead length.
	localparam logic [7:0] MASK_LEAD2 = 8'h1F;
	localparam logic [7:0] MASK_LEAD3 = 8'h0F;
	localparam logic [7:0] MASK_LEAD4 = 8'h07;
	localparam logic [7:0] MASK_LEAD5 = 8'h03;
	localparam logic [7:0] MASK_LEAD6 = 8'h01;
	localparam logic [7:0] MASK_CONT  = 8'h3F;
	localparam logic [7:0] MASK_TOP2  = 8'hC0;
	localparam logic [7:0] CONT_TAG   = 8'h80;
	localparam logic [7:0] MASK_C0C1  = 8'hFE;
	localparam logic [7:0] OVERLONG2  = 8'hC0;

	// Leads whose second byte needs the overlong check.
	localparam logic [7:0] LEAD_E0 = 8'hE0;
	localparam logic [7:0] LEAD_F0 = 8'hF0;
	localparam logic [7:0] LEAD_F8 = 8'hF8;
	localparam logic [7:0] LEAD_FC = 8'hFC;

	localparam logic [2:0] MAX_SHORT_LEN = 3'd3;

	// Register map.
	localparam int unsigned PADDR_BITS = 3;
	localparam logic [PADDR_BITS-1:0] ADDR_LIMIT3 = 3'd0;

endpackage

`default_nettype wire

### hdl/utf8d_step.sv
// Combinational decode of one byte against the current sequence state.
`timescale 1ns / 1ps
`default_nettype none

module utf8d_step #(
	parameter int COUNT_BITS = 16
) (
	input  utf8d_pkg::utf8d_in_t    beat,
	input  utf8d_pkg::utf8d_state_t st,
	input  logic [COUNT_BITS-1:0]   count,
	input  logic                    limit3,
	output utf8d_pkg::utf8d_state_t st_nxt,
	output logic [COUNT_BITS-1:0]   count_nxt,
	output utf8d_pkg::utf8d_emit_t  out
);
	import utf8d_pkg::*;

	logic [7:0]            b;
	logic                  eob;
	logic [2:0]            nb;
	logic [7:0]            mask;
	logic                  bad_lead;
	logic [7:0]            ol_mask;
	logic [30:0]           acc_shift;
	logic [2:0]            rem_dec;
	logic [COUNT_BITS-1:0] count_inc;
	logic [31:0]           cnt_old_ext;
	logic [31:0]           cnt_inc_ext;

	assign b   = beat.data_byte;
	assign eob = beat.end_of_buffer;

	// Saturating increment of the character count.
	assign count_inc   = (&count) ? count : count + COUNT_BITS'(1);
	assign cnt_old_ext = 32'(count);
	assign cnt_inc_ext = 32'(count_inc);

	// Lead byte classification.
	always_comb begin
		nb       = 3'd0;
		mask     = 8'h00;
		bad_lead = 1'b0;
		if (b < LEAD2_END) begin
			nb   = 3'd2;
			mask = MASK_LEAD2;
		end else if (b < LEAD3_END) begin
			nb   = 3'd3;
			mask = MASK_LEAD3;
		end else if (b < LEAD4_END) begin
			nb   = 3'd4;
			mask = MASK_LEAD4;
		end else if (b < LEAD5_END) begin
			nb   = 3'd5;
			mask = MASK_LEAD5;
		end else if (b < LEAD6_END) begin
			nb   = 3'd6;
			mask = MASK_LEAD6;
		end else begin
			bad_lead = 1'b1;
		end
	end

	// Overlong mask for the second byte, chosen by the stored lead.
	always_comb begin
		ol_mask = 8'h00;
		if (st.lead_byte == LEAD_E0) begin
			ol_mask = LEAD_E0;
		end else if (st.lead_byte == LEAD_F0) begin
			ol_mask = LEAD_F0;
		end else if (st.lead_byte == LEAD_F8) begin
			ol_mask = LEAD_F8;
		end else if (st.lead_byte == LEAD_FC) begin
			ol_mask = LEAD_FC;
		end
	end

	assign acc_shift = {st.accumulator[24:0], b[5:0]};
	assign rem_dec   = st.bytes_remaining - 3'd1;

	// Next state and result for this byte.
	always_comb begin
		logic err;
		logic chr;
		logic [30:0] cp;
		err       = 1'b0;
		chr       = 1'b0;
		cp        = '0;
		st_nxt    = st;
		count_nxt = count;
		out       = '0;

		if (st.discarding) begin
			if (eob) begin
				st_nxt    = '0;
				count_nxt = '0;
			end
		end else if (st.bytes_remaining == 3'd0) begin
			if (b < LEAD_ASCII_END) begin
				chr = 1'b1;
				cp  = 31'(b);
			end else if (b < LEAD_CONT_END || bad_lead) begin
				err = 1'b1;
			end else if (limit3 && nb > MAX_SHORT_LEN) begin
				err = 1'b1;
			end else if ((b & MASK_C0C1) == OVERLONG2) begin
				err = 1'b1;
			end else if (eob) begin
				// Truncated: lead byte closes the buffer.
				err = 1'b1;
			end else begin
				st_nxt.bytes_remaining = nb - 3'd1;
				st_nxt.sequence_length = nb;
				st_nxt.lead_byte       = b;
				st_nxt.second_pending  = 1'b1;
				st_nxt.accumulator     = 31'(b & mask);
			end
		end else begin
			if ((b & MASK_TOP2) != CONT_TAG) begin
				err = 1'b1;
			end else if (st.second_pending && ol_mask != 8'h00
					&& (b & ol_mask) == CONT_TAG) begin
				err = 1'b1;
			end else if (rem_dec == 3'd0) begin
				chr = 1'b1;
				cp  = acc_shift;
			end else if (eob) begin
				err = 1'b1;
			end else begin
				st_nxt.second_pending  = 1'b0;
				st_nxt.accumulator     = acc_shift;
				st_nxt.bytes_remaining = rem_dec;
			end
		end

		// Error beat: ends the buffer and drops the rest unless this byte ended it.
		if (err) begin
			out.emit            = 1'b1;
			out.res.is_error    = 1'b1;
			out.res.buffer_done = 1'b1;
			out.res.char_count  = cnt_old_ext[15:0];
			st_nxt              = '0;
			st_nxt.discarding   = !eob;
			count_nxt           = '0;
		end

		// Character beat.
		if (chr) begin
			out.emit               = 1'b1;
			out.res.code_point     = cp;
			out.res.buffer_done    = eob;
			out.res.char_count     = cnt_inc_ext[15:0];
			st_nxt.bytes_remaining = '0;
			st_nxt.sequence_length = '0;
			st_nxt.second_pending  = 1'b0;
			st_nxt.accumulator     = '0;
			count_nxt              = count_inc;
			if (eob) begin
				st_nxt    = '0;
				count_nxt = '0;
			end
		end
	end

endmodule

`default_nettype wire

### hdl/utf8d_outreg.sv
// Result register that holds a beat until the consumer takes it.
`timescale 1ns / 1ps
`default_nettype none

module utf8d_outreg (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   load,
	input  utf8d_pkg::utf8d_emit_t step,
	output logic                   can_load,
	output logic                   out_valid,
	input  logic                   out_ready,
	output utf8d_pkg::utf8d_out_t  out_data
);
	import utf8d_pkg::*;

	logic       valid_q;
	utf8d_out_t data_q;

	// Free when empty or when the waiting beat leaves this cycle.
	assign can_load  = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign out_data  = data_q;

	// Valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= step.emit;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	// Payload.
	always_ff @(posedge clk) begin
		if (load && step.emit) begin
			data_q <= step.res;
		end
	end

endmodule

`default_nettype wire

### hdl/utf8_stream_decoder_core.sv
// Top level of the UTF-8 stream decoder: input register, decode step, result register, APB.
//
//  Channel  Direction  Handshake          Beat
//  in       sink       in_valid/in_ready  utf8d_in_t  (data_byte, end_of_buffer)
//  out      source     out_valid/out_ready utf8d_out_t (code_point, is_error, buffer_done,
//                                         char_count)
//  apb      slave      psel/penable       limit_to_three_bytes at address 0
//
// One byte is taken per cycle unless the result register stalls; each result is registered.
// The decode of a byte is a single pass through the step logic between the input
// register and the result register, with the sequence state updated in the same cycle.
// Reset clears the sequence state, the count and the mode register.
// A stalled result register holds the byte in the input register, and in_ready stays low
// until the result register can take a beat again.
`timescale 1ns / 1ps
`default_nettype none

module utf8_stream_decoder_core #(
	parameter int COUNT_BITS = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  utf8d_pkg::utf8d_in_t                in_data,
	output logic                                out_valid,
	input  logic                                out_ready,
	output utf8d_pkg::utf8d_out_t               out_data,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [utf8d_pkg::PADDR_BITS-1:0]    paddr,
	input  logic [31:0]                         pwdata,
	output logic [31:0]                         prdata,
	output logic                                pready
);
	import utf8d_pkg::*;

	logic                  limit3_q;
	logic                  valid_s1;
	utf8d_in_t             beat_s1;
	utf8d_state_t          st_q;
	utf8d_state_t          st_nxt;
	logic [COUNT_BITS-1:0] count_q;
	logic [COUNT_BITS-1:0] count_nxt;
	utf8d_emit_t           step;
	logic                  can_load;
	logic                  advance;

	// Configuration port.
	assign pready = 1'b1;
	assign prdata = (paddr == ADDR_LIMIT3) ? {31'd0, limit3_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit3_q <= 1'b0;
		end else if (psel && penable && pwrite && paddr == ADDR_LIMIT3) begin
			limit3_q <= pwdata[0];
		end
	end

	// Input register: a byte moves on when the result register can take its beat.
	assign advance  = valid_s1 && can_load;
	assign in_ready = !valid_s1 || can_load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			beat_s1 <= in_data;
		end
	end

	// Decode step.
	utf8d_step #(
		.COUNT_BITS(COUNT_BITS)
	) u_step (
		.beat      (beat_s1),
		.st        (st_q),
		.count     (count_q),
		.limit3    (limit3_q),
		.st_nxt    (st_nxt),
		.count_nxt (count_nxt),
		.out       (step)
	);

	// Sequence state and character count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= '0;
			count_q <= '0;
		end else if (advance) begin
			st_q    <= st_nxt;
			count_q <= count_nxt;
		end
	end

	// Result register.
	utf8d_outreg u_outreg (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (advance),
		.step      (step),
		.can_load  (can_load),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	// An error beat never carries a code point and always closes the buffer.
	a_err_beat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.is_error |-> out_data.code_point == '0
			&& out_data.buffer_done)
		else $error("error beat with code point or without buffer end");

	// An error that does not end the buffer puts the decoder into discard.
	a_err_discard: assert property (@(posedge clk) disable iff (!arst_n)
		advance && step.emit && step.res.is_error && !beat_s1.end_of_buffer
			|=> st_q.discarding)
		else $error("error without end of buffer did not start discarding");

	// No beat comes out while bytes are being dropped.
	a_discard_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		advance && st_q.discarding |-> !step.emit)
		else $error("beat produced while discarding");

	// At most five continuation bytes are ever awaited.
	a_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.bytes_remaining <= 3'd5)
		else $error("continuation count out of range");

	// A waiting result holds the input byte in place.
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && out_valid && !out_ready |=> valid_s1 && $stable(beat_s1))
		else $error("input byte lost during output stall");

endmodule

`default_nettype wire

### bench/utf8_stream_decoder_core_test.sv
// Self-checking testbench for the UTF-8 stream decoder: byte stimulus, result prediction and checks.
`timescale 1ns / 1ps

module utf8_stream_decoder_core_test;
	import utf8d_pkg::*;

	localparam int COUNT_BITS = 16;
	localparam int SETTLE_CYCLES = 10;
	localparam int DRAIN_LIMIT = 5000;
	localparam int LONG_HOLD_CYCLES = 64;
	localparam int MAX_REPORTS = 100;
	localparam int TAIL_CHARS = 16;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic in_valid = 1'b0;
	wire logic in_ready;
	utf8d_in_t in_data = '0;
	wire logic out_valid;
	logic out_ready = 1'b0;
	utf8d_out_t out_data;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [PADDR_BITS-1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	wire logic [31:0] prdata;
	wire logic pready;

	utf8_stream_decoder_core #(
		.COUNT_BITS(COUNT_BITS)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always #1 clk = ~clk;

	// Bytes waiting to be offered, and results the decoder still owes us.
	utf8d_in_t byte_backlog[$];
	utf8d_out_t awaited_results[$];
	int unsigned bytes_queued = 0;
	int unsigned bytes_accepted = 0;
	int unsigned results_seen = 0;
	int unsigned errors_seen = 0;
	int unsigned error_count = 0;
	bit quiet = 1'b0;

	// Our own copy of the decoder state and its mode register.
	logic mode_limit3 = 1'b0;
	logic [2:0] pend_conts;
	logic [7:0] seq_lead;
	logic second_due;
	logic [30:0] cp_accum;
	logic [COUNT_BITS-1:0] buf_chars;
	logic dropping;

	task automatic clear_buffer();
		pend_conts = '0;
		seq_lead = '0;
		second_due = 1'b0;
		cp_accum = '0;
		buf_chars = '0;
		dropping = 1'b0;
	endtask

	task automatic emit_char_result(input logic [30:0] cp, input logic eob);
		utf8d_out_t r;
		if (buf_chars != '1) begin
			buf_chars++;
		end
		r.code_point = cp;
		r.is_error = 1'b0;
		r.buffer_done = eob;
		r.char_count = buf_chars[15:0];
		awaited_results.push_back(r);
		pend_conts = '0;
		second_due = 1'b0;
		cp_accum = '0;
		if (eob) begin
			clear_buffer();
		end
	endtask

	// An error closes the buffer; without end-of-buffer the rest of it is dropped.
	task automatic emit_error_result(input logic eob);
		utf8d_out_t r;
		r.code_point = '0;
		r.is_error = 1'b1;
		r.buffer_done = 1'b1;
		r.char_count = buf_chars[15:0];
		awaited_results.push_back(r);
		clear_buffer();
		dropping = !eob;
	endtask

	// Works out what one accepted byte produces and moves the state on.
	task automatic decode_byte(input utf8d_in_t beat);
		logic [7:0] b;
		logic eob;
		logic [2:0] seq_len;
		logic [7:0] payload_mask;
		logic overlong;
		b = beat.data_byte;
		eob = beat.end_of_buffer;
		if (dropping) begin
			if (eob) begin
				clear_buffer();
			end
		end else if (pend_conts == 0) begin
			if (b < LEAD_ASCII_END) begin
				emit_char_result({23'd0, b}, eob);
			end else if (b < LEAD_CONT_END || b >= LEAD6_END) begin
				emit_error_result(eob);
			end else begin
				if (b < LEAD2_END) begin
					seq_len = 3'd2;
					payload_mask = MASK_LEAD2;
				end else if (b < LEAD3_END) begin
					seq_len = 3'd3;
					payload_mask = MASK_LEAD3;
				end else if (b < LEAD4_END) begin
					seq_len = 3'd4;
					payload_mask = MASK_LEAD4;
				end else if (b < LEAD5_END) begin
					seq_len = 3'd5;
					payload_mask = MASK_LEAD5;
				end else begin
					seq_len = 3'd6;
					payload_mask = MASK_LEAD6;
				end
				if ((mode_limit3 && seq_len > MAX_SHORT_LEN) ||
						((b & MASK_C0C1) == OVERLONG2) || eob) begin
					emit_error_result(eob);
				end else begin
					pend_conts = seq_len - 3'd1;
					seq_lead = b;
					second_due = 1'b1;
					cp_accum = {23'd0, b & payload_mask};
				end
			end
		end else if ((b & MASK_TOP2) != CONT_TAG) begin
			emit_error_result(eob);
		end else begin
			// The shortest-form check on the second byte uses the lead itself as mask.
			overlong = second_due &&
				(seq_lead == LEAD_E0 || seq_lead == LEAD_F0 ||
				 seq_lead == LEAD_F8 || seq_lead == LEAD_FC) &&
				((b & seq_lead) == CONT_TAG);
			if (overlong) begin
				emit_error_result(eob);
			end else begin
				second_due = 1'b0;
				cp_accum = {cp_accum[24:0], b[5:0]};
				pend_conts = pend_conts - 3'd1;
				if (pend_conts == 0) begin
					emit_char_result(cp_accum, eob);
				end else if (eob) begin
					emit_error_result(eob);
				end
			end
		end
	endtask

	// Sender: offers bytes from the backlog, with random bursts of idle cycles.
	int unsigned send_gap = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_data <= '0;
			send_gap <= 0;
		end else begin
			if (in_valid && in_ready) begin
				decode_byte(in_data);
				bytes_accepted++;
			end
			if (!in_valid || in_ready) begin
				if (send_gap != 0) begin
					send_gap <= send_gap - 1;
					in_valid <= 1'b0;
				end else if (byte_backlog.size() != 0) begin
					if (!quiet && $urandom_range(0, 9) == 0) begin
						send_gap <= $urandom_range(0, 5);
						in_valid <= 1'b0;
					end else begin
						in_data <= byte_backlog.pop_front();
						in_valid <= 1'b1;
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	task automatic report_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		error_count++;
		if (error_count <= MAX_REPORTS) begin
			$display("%0t ns: %s mismatch, expected %0h, got %0h", $time, name, want, got);
		end else if (error_count == MAX_REPORTS + 1) begin
			$display("%0t ns: further mismatches are counted but not shown", $time);
		end
	endtask

	// Compares one result beat with the oldest prediction.
	task automatic check_result(input utf8d_out_t got);
		utf8d_out_t want;
		if (awaited_results.size() == 0) begin
			report_field("unexpected result", 32'd0, {1'b0, got.code_point});
		end else begin
			want = awaited_results.pop_front();
			if (got.code_point !== want.code_point) begin
				report_field("code_point", {1'b0, want.code_point}, {1'b0, got.code_point});
			end
			if (got.is_error !== want.is_error) begin
				report_field("is_error", {31'd0, want.is_error}, {31'd0, got.is_error});
			end
			if (got.buffer_done !== want.buffer_done) begin
				report_field("buffer_done", {31'd0, want.buffer_done},
					{31'd0, got.buffer_done});
			end
			if (got.char_count !== want.char_count) begin
				report_field("char_count", {16'd0, want.char_count}, {16'd0, got.char_count});
			end
			results_seen++;
			if (want.is_error) begin
				errors_seen++;
			end
		end
	endtask

	// Receiver: checks result beats, stalls at random and now and then for a long stretch.
	int unsigned recv_gap = 0;
	int unsigned long_hold = 0;
	int unsigned next_hold_at = 300;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			recv_gap <= 0;
			long_hold <= 0;
		end else begin
			if (out_valid && out_ready) begin
				check_result(out_data);
			end
			if (long_hold != 0) begin
				long_hold <= long_hold - 1;
				out_ready <= 1'b0;
			end else if (!quiet && results_seen >= next_hold_at) begin
				next_hold_at <= results_seen + 700;
				long_hold <= LONG_HOLD_CYCLES - 1;
				out_ready <= 1'b0;
			end else if (recv_gap != 0) begin
				recv_gap <= recv_gap - 1;
				out_ready <= 1'b0;
			end else if (!quiet && $urandom_range(0, 9) == 0) begin
				recv_gap <= $urandom_range(0, 5);
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	task automatic queue_byte(input logic [7:0] value, input logic eob);
		utf8d_in_t beat;
		beat.data_byte = value;
		beat.end_of_buffer = eob;
		byte_backlog.push_back(beat);
		bytes_queued++;
	endtask

	// One buffer of random characters, sometimes with a damaged or cut-off byte, or pure noise.
	task automatic queue_random_frame(input bit limit3);
		logic [7:0] frame[$];
		int unsigned kind;
		int unsigned len;
		int unsigned cut;
		logic [7:0] lead_prefix;
		logic [7:0] lead_mask;
		kind = $urandom_range(0, 9);
		if (kind == 0) begin
			repeat ($urandom_range(1, 8)) frame.push_back(8'($urandom_range(0, 255)));
		end else begin
			repeat ($urandom_range(1, 10)) begin
				if (limit3 && $urandom_range(0, 9) != 0) begin
					len = $urandom_range(1, 3);
				end else begin
					len = $urandom_range(1, 6);
				end
				// Each lead prefix is the upper bound of the previous lead range.
				case (len)
					2: begin
						lead_prefix = LEAD_CONT_END;
						lead_mask = MASK_LEAD2;
					end
					3: begin
						lead_prefix = LEAD2_END;
						lead_mask = MASK_LEAD3;
					end
					4: begin
						lead_prefix = LEAD3_END;
						lead_mask = MASK_LEAD4;
					end
					5: begin
						lead_prefix = LEAD4_END;
						lead_mask = MASK_LEAD5;
					end
					default: begin
						lead_prefix = LEAD5_END;
						lead_mask = MASK_LEAD6;
					end
				endcase
				if (len == 1) begin
					frame.push_back(8'($urandom_range(0, 127)));
				end else begin
					frame.push_back(lead_prefix | (8'($urandom) & lead_mask));
					repeat (len - 1) frame.push_back(CONT_TAG | (8'($urandom) & MASK_CONT));
				end
			end
			if (kind == 1) begin
				frame[$urandom_range(0, frame.size() - 1)] = 8'($urandom_range(0, 255));
			end else if (kind == 2) begin
				cut = $urandom_range(1, frame.size());
				while (frame.size() > cut) void'(frame.pop_back());
			end
		end
		foreach (frame[i]) begin
			queue_byte(frame[i], (i == frame.size() - 1) ||
				(kind == 0 && $urandom_range(0, 7) == 0));
		end
	endtask

	task automatic queue_random_bytes(input int unsigned count, input bit limit3);
		int unsigned target;
		target = bytes_queued + count;
		while (bytes_queued < target) queue_random_frame(limit3);
	endtask

	// Waits until every byte is taken and every result is in, then lets the pipeline settle.
	task automatic wait_until_drained();
		do @(posedge clk); while (bytes_accepted != bytes_queued || awaited_results.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_limit3(input logic value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_LIMIT3;
		pwdata <= {31'd0, value};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		mode_limit3 = value;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// Stimulus sequence and end of run.
	initial begin
		int unsigned drain_cycles;
		clear_buffer();
		mode_limit3 = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// ASCII extremes, two-byte and six-byte extremes.
		queue_byte(8'h00, 1'b0);
		queue_byte(8'h7F, 1'b1);
		queue_byte(8'hC2, 1'b0);
		queue_byte(8'h80, 1'b0);
		queue_byte(8'hDF, 1'b0);
		queue_byte(8'hBF, 1'b1);
		queue_byte(8'hFD, 1'b0);
		repeat (4) queue_byte(8'hBF, 1'b0);
		queue_byte(8'hBF, 1'b1);
		// Bad leads, the third one followed by dropped bytes.
		queue_byte(8'h80, 1'b1);
		queue_byte(8'hFE, 1'b1);
		queue_byte(8'hFF, 1'b0);
		queue_byte(8'h41, 1'b1);
		// Overlong two-byte lead and overlong second bytes.
		queue_byte(8'hC0, 1'b1);
		queue_byte(8'hE0, 1'b0);
		queue_byte(8'h80, 1'b1);
		queue_byte(8'hFC, 1'b0);
		queue_byte(8'h83, 1'b1);
		// Bad continuation, then a sequence cut short by end of buffer.
		queue_byte(8'hE1, 1'b0);
		queue_byte(8'h41, 1'b1);
		queue_byte(8'hF0, 1'b0);
		queue_byte(8'h90, 1'b1);
		// A four-byte sequence left open across the mode change.
		queue_byte(8'hF4, 1'b0);
		queue_byte(8'h8F, 1'b0);
		wait_until_drained();

		write_limit3(1'b1);
		queue_byte(8'hBF, 1'b0);
		queue_byte(8'hBF, 1'b1);
		queue_byte(8'hF0, 1'b1);
		queue_byte(8'hEF, 1'b0);
		queue_byte(8'hBF, 1'b0);
		queue_byte(8'hBF, 1'b1);
		queue_random_bytes(700, 1'b1);
		wait_until_drained();

		write_limit3(1'b0);
		queue_random_bytes(1000, 1'b0);
		wait_until_drained();

		// Last part without idling: a short ASCII run closed by a three-byte character, then a one-byte buffer.
		quiet = 1'b1;
		repeat (TAIL_CHARS) queue_byte(8'($urandom_range(0, 127)), 1'b0);
		queue_byte(8'hE2, 1'b0);
		queue_byte(8'h82, 1'b0);
		queue_byte(8'hAC, 1'b1);
		queue_byte(8'h41, 1'b1);

		do @(posedge clk); while (bytes_accepted != bytes_queued);
		drain_cycles = 0;
		while (awaited_results.size() != 0 && drain_cycles < DRAIN_LIMIT) begin
			@(posedge clk);
			drain_cycles++;
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (awaited_results.size() != 0) begin
			error_count++;
			$display("%0t ns: %0d results never arrived", $time, awaited_results.size());
		end

		$display("Run covered %0d bytes in both mode settings, a long receiver hold-off",
			bytes_accepted);
		$display("and an idle-free tail; %0d results checked, %0d of them errors.",
			results_seen, errors_seen);
		if (error_count == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

	// Guard against a hung run.
	initial begin
		#2000000;
		$display("%0t ns: run timed out", $time);
		$display("FAILED: results differ");
		$finish;
	end

endmodule

### files.f
hdl/utf8d_pkg.sv
hdl/utf8d_step.sv
hdl/utf8d_outreg.sv
hdl/utf8_stream_decoder_core.sv
bench/utf8_stream_decoder_core_test.sv
